// ===== hdl/salc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, types and codes of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int SET_BITS_MAX = 6;
    localparam int WAYS         = 8;
    localparam int ADDR_W       = 32;

    localparam int SETS      = 2 ** SET_BITS_MAX;
    localparam int TAG_W     = ADDR_W;
    localparam int STAMP_W   = 64;
    localparam int AGE_W     = 32;
    localparam int CNT_W     = 32;
    localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // configuration register fields
    localparam int CFG_SET_W    = 3;
    localparam int CFG_WAYS_W   = 4;
    localparam int CFG_OFFSET_W = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CFG_SET_W-1:0]    SET_BITS_RST  = 3'd4;
    localparam logic [CFG_WAYS_W-1:0]   WAYS_RST      = 4'd1;
    localparam logic [CFG_OFFSET_W-1:0] OFFSET_RST    = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_BITS    = 2'd0,
        REG_WAYS        = 2'd1,
        REG_OFFSET_BITS = 2'd2
    } cfg_reg_e;

    // command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DECIDE,
        ST_WRITE
    } state_e;

    typedef logic [SET_BITS_MAX-1:0] set_idx_t;
    typedef logic [WAY_IDX_W-1:0]    way_idx_t;
    typedef logic [CFG_WAYS_W-1:0]   way_cnt_t;
    typedef logic [TAG_W-1:0]        tag_t;
    typedef logic [STAMP_W-1:0]      stamp_t;
    typedef logic [AGE_W-1:0]        age_t;

    // one line; the stamp is the item count at the last touch
    typedef struct packed {
        logic   valid;
        tag_t   tag;
        stamp_t stamp;
    } way_t;

    localparam int WAY_W = $bits(way_t);

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic capture;
        logic decide;
    } eval_ctl_t;

    typedef struct packed {
        logic     hit;
        logic     fill;
        way_idx_t way;
    } decision_t;

endpackage

// ===== hdl/salc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_req_if
// Access request channel: command and byte address.
// ----------------------------------------------------------------------------
interface salc_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  command;
    logic [salc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

// ===== hdl/salc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_rsp_if
// Access result channel: outcome, running totals and end-of-item flag.
// ----------------------------------------------------------------------------
interface salc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 outcome;
    logic [salc_pkg::CNT_W-1:0] hit_total;
    logic [salc_pkg::CNT_W-1:0] miss_total;
    logic [salc_pkg::CNT_W-1:0] eviction_total;
    logic                       last_of_item;

    modport source (output valid, output outcome, output hit_total, output miss_total,
                    output eviction_total, output last_of_item, input ready);
    modport sink   (input valid, input outcome, input hit_total, input miss_total,
                    input eviction_total, input last_of_item, output ready);
endinterface

// ===== hdl/salc_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface salc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [salc_pkg::CFG_IDX_W-1:0]  index;
    logic [salc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/salc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_ram
// Simple dual-port synchronous RAM with per-lane write mask and registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int DEPTH  = 64,
    parameter int LANES  = 8,
    parameter int LANE_W = 8
) (
    input  logic                                               clk,
    input  logic                                               rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       rd_addr,
    output logic [LANES*LANE_W-1:0]                            rd_data,
    input  logic                                               wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       wr_addr,
    input  logic [LANES-1:0]                                   wr_mask,
    input  logic [LANES*LANE_W-1:0]                            wr_data
);

    logic [LANES*LANE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (wr_mask[l])
                begin
                    mem[wr_addr][l*LANE_W +: LANE_W] <= wr_data[l*LANE_W +: LANE_W];
                end
            end
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/salc_way_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_way_eval
// Two-stage set evaluation: per-way match, free and age, then hit, fill or
// least recently used victim selection.
// ----------------------------------------------------------------------------
module salc_way_eval (
    input  logic                 clk,
    input  salc_pkg::eval_ctl_t  ctl,
    input  salc_pkg::row_t       row,
    input  logic                 row_live,
    input  salc_pkg::tag_t       tag,
    input  salc_pkg::way_cnt_t   ways,
    input  salc_pkg::stamp_t     now,
    output salc_pkg::decision_t  decision
);
    import salc_pkg::*;

    logic [WAYS-1:0] match_next;
    logic [WAYS-1:0] free_next;
    age_t            age_next [WAYS];
    stamp_t          diff     [WAYS];

    logic [WAYS-1:0] match_reg;
    logic [WAYS-1:0] free_reg;
    age_t            age_reg  [WAYS];

    decision_t       decision_next;
    decision_t       decision_reg;

    age_t            cand_age [WAYS];
    way_idx_t        cand_way [WAYS];

    // stage a: per-way flags and saturated age
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            diff[w] = now - row[w].stamp;
            if (CFG_WAYS_W'(w) < ways)
            begin
                match_next[w] = row_live && row[w].valid && (row[w].tag == tag);
                free_next[w]  = !(row_live && row[w].valid);
                age_next[w]   = (|diff[w][STAMP_W-1:AGE_W]) ? '1 : diff[w][AGE_W-1:0];
            end
            else
            begin
                match_next[w] = 1'b0;
                free_next[w]  = 1'b0;
                age_next[w]   = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            match_reg <= match_next;
            free_reg  <= free_next;
            for (int w = 0; w < WAYS; w++)
            begin
                age_reg[w] <= age_next[w];
            end
        end
    end

    // stage b: hit way, else lowest free way, else oldest way by pairwise reduction, left side wins ties
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            cand_age[w] = age_reg[w];
            cand_way[w] = WAY_IDX_W'(w);
        end
        for (int step = 1; step < WAYS; step = step * 2)
        begin
            for (int i = 0; i < WAYS; i = i + 2 * step)
            begin
                if ((i + step < WAYS) && (cand_age[i + step] > cand_age[i]))
                begin
                    cand_age[i] = cand_age[i + step];
                    cand_way[i] = cand_way[i + step];
                end
            end
        end

        decision_next.hit  = |match_reg;
        decision_next.fill = 1'b0;
        decision_next.way  = cand_way[0];
        if (|match_reg)
        begin
            for (int w = WAYS - 1; w >= 0; w--)
            begin
                if (match_reg[w])
                begin
                    decision_next.way = WAY_IDX_W'(w);
                end
            end
        end
        else if (|free_reg)
        begin
            decision_next.fill = 1'b1;
            for (int w = WAYS - 1; w >= 0; w--)
            begin
                if (free_reg[w])
                begin
                    decision_next.way = WAY_IDX_W'(w);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.decide)
        begin
            decision_reg <= decision_next;
        end
    end

    assign decision = decision_reg;

endmodule

// ===== hdl/set_assoc_lru_cache_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache tracker with least recently used replacement.
// ----------------------------------------------------------------------------
// req carries a load, store or modify of a byte address; rsp returns one
// result per cache access (a modify gives two, last_of_item marks the final
// one) with the outcome and saturating hit, miss and eviction totals.
// cfg writes set_index_bits, ways_in_use and block_offset_bits; it is always
// ready. The user must write it only while no request is in flight; the
// block itself does not enforce this. Each access runs through a row read
// from the set memory (one row holds all ways of a set), a per-way compare
// and age stage, a victim select stage and a write-back of the touched way.
// The next request is accepted once the previous item's last write-back is
// done. Command 3 is accepted and gives no result. Line age is kept as a
// 64-bit item stamp, so aging every line costs nothing per item.
// After reset all lines are invalid (64 row-valid flops), totals are zero
// and the registers take their reset values; no clearing pass is needed.
// The result sits in an output register; while rsp stalls, a finished access
// waits in its write-back cycle and the set memory is not updated.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model (
    input  logic         clk,
    input  logic         rst_n,
    salc_req_if.sink     req,
    salc_rsp_if.source   rsp,
    salc_cfg_if.sink     cfg
);
    import salc_pkg::*;

    state_e                  state_reg;
    state_e                  state_next;

    logic [CFG_SET_W-1:0]    set_bits_reg;
    logic [CFG_WAYS_W-1:0]   ways_reg;
    logic [CFG_OFFSET_W-1:0] offset_reg;

    logic                    pending_reg;
    set_idx_t                set_reg;
    tag_t                    tag_reg;
    stamp_t                  item_count_reg;
    logic [CNT_W-1:0]        hit_cnt_reg;
    logic [CNT_W-1:0]        miss_cnt_reg;
    logic [CNT_W-1:0]        evict_cnt_reg;
    logic [CNT_W-1:0]        hit_cnt_next;
    logic [CNT_W-1:0]        miss_cnt_next;
    logic [CNT_W-1:0]        evict_cnt_next;
    logic [SETS-1:0]         row_valid_reg;

    logic                    rsp_valid_reg;
    outcome_e                outcome_reg;
    outcome_e                outcome_next;
    logic                    last_reg;

    // control
    logic                    req_ready;
    logic                    rd_en;
    logic                    wr_fire;
    eval_ctl_t               eval_ctl;
    logic                    req_fire;
    logic                    is_access;
    logic                    item_done;

    // geometry
    logic [CFG_SET_W-1:0]    sbits;
    way_cnt_t                ways_eff;
    logic [5:0]              tag_shift;
    logic [ADDR_W-1:0]       addr_sh;
    logic [SET_BITS_MAX:0]   set_one;
    logic [SET_BITS_MAX:0]   set_mask;
    set_idx_t                set_next;
    tag_t                    tag_next;

    // memory
    logic [WAYS*WAY_W-1:0]   rd_data;
    row_t                    wr_row;
    logic [WAYS-1:0]         wr_mask;
    decision_t               decision;
    way_t                    new_way;

    assign sbits    = (set_bits_reg > CFG_SET_W'(SET_BITS_MAX)) ?
                      CFG_SET_W'(SET_BITS_MAX) : set_bits_reg;
    assign ways_eff = (ways_reg == '0) ? CFG_WAYS_W'(1) :
                      ((ways_reg > CFG_WAYS_W'(WAYS)) ? CFG_WAYS_W'(WAYS) : ways_reg);
    assign tag_shift = 6'(offset_reg) + 6'(sbits);
    assign addr_sh   = req.address >> offset_reg;
    assign set_one   = (SET_BITS_MAX + 1)'(1);
    assign set_mask  = (set_one << sbits) - set_one;
    assign set_next  = addr_sh[SET_BITS_MAX-1:0] & set_mask[SET_BITS_MAX-1:0];
    assign tag_next  = (tag_shift >= 6'(ADDR_W)) ? '0 : (req.address >> tag_shift);

    assign is_access = (req.command == CMD_LOAD) || (req.command == CMD_STORE) ||
                       (req.command == CMD_MODIFY);
    assign req_fire  = req.valid && req_ready;
    assign item_done = (req_fire && !is_access) || (wr_fire && !pending_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && is_access)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = pending_reg ? ST_READ : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready        = 1'b0;
        rd_en            = 1'b0;
        eval_ctl.capture = 1'b0;
        eval_ctl.decide  = 1'b0;
        wr_fire          = 1'b0;
        unique case (state_reg)
            ST_IDLE:   req_ready        = 1'b1;
            ST_READ:   rd_en            = 1'b1;
            ST_EVAL:   eval_ctl.capture = 1'b1;
            ST_DECIDE: eval_ctl.decide  = 1'b1;
            ST_WRITE:  wr_fire          = !rsp_valid_reg || rsp.ready;
            default:   req_ready        = 1'b0;
        endcase
    end

    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= SET_BITS_RST;
            ways_reg     <= WAYS_RST;
            offset_reg   <= OFFSET_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SET_BITS:    set_bits_reg <= cfg.data[CFG_SET_W-1:0];
                REG_WAYS:        ways_reg     <= cfg.data[CFG_WAYS_W-1:0];
                REG_OFFSET_BITS: offset_reg   <= cfg.data[CFG_OFFSET_W-1:0];
                default:         set_bits_reg <= set_bits_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            set_reg <= set_next;
            tag_reg <= tag_next;
        end
    end

    // saturating totals after this access
    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        outcome_next   = OUT_EVICT;
        if (decision.hit)
        begin
            outcome_next = OUT_HIT;
            if (hit_cnt_reg != '1)
            begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end
        else
        begin
            if (decision.fill)
            begin
                outcome_next = OUT_FILL;
            end
            else if (evict_cnt_reg != '1)
            begin
                evict_cnt_next = evict_cnt_reg + 1'b1;
            end
            if (miss_cnt_reg != '1)
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            item_count_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            row_valid_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                pending_reg <= (req.command == CMD_MODIFY);
            end
            else if (wr_fire)
            begin
                pending_reg <= 1'b0;
            end
            if (item_done)
            begin
                item_count_reg <= item_count_reg + 1'b1;
            end
            if (wr_fire)
            begin
                hit_cnt_reg            <= hit_cnt_next;
                miss_cnt_reg           <= miss_cnt_next;
                evict_cnt_reg          <= evict_cnt_next;
                row_valid_reg[set_reg] <= 1'b1;
                rsp_valid_reg          <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            outcome_reg <= outcome_next;
            last_reg    <= !pending_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.outcome        = outcome_reg;
    assign rsp.hit_total      = hit_cnt_reg;
    assign rsp.miss_total     = miss_cnt_reg;
    assign rsp.eviction_total = evict_cnt_reg;
    assign rsp.last_of_item   = last_reg;

    // write-back: touched way only, or the whole row on its first write
    always_comb
    begin
        new_way.valid = 1'b1;
        new_way.tag   = tag_reg;
        new_way.stamp = item_count_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (decision.way == WAY_IDX_W'(w))
            begin
                wr_row[w]  = new_way;
                wr_mask[w] = 1'b1;
            end
            else
            begin
                wr_row[w]  = '0;
                wr_mask[w] = !row_valid_reg[set_reg];
            end
        end
    end

    salc_ram #(
        .DEPTH  (SETS),
        .LANES  (WAYS),
        .LANE_W (WAY_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (set_reg),
        .rd_data (rd_data),
        .wr_en   (wr_fire),
        .wr_addr (set_reg),
        .wr_mask (wr_mask),
        .wr_data (wr_row)
    );

    salc_way_eval u_way_eval (
        .clk      (clk),
        .ctl      (eval_ctl),
        .row      (row_t'(rd_data)),
        .row_live (row_valid_reg[set_reg]),
        .tag      (tag_reg),
        .ways     (ways_eff),
        .now      (item_count_reg),
        .decision (decision)
    );

endmodule

// ===== bench/salc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_checker
// Watches the request, result and register channels of the LRU cache model,
// keeps its own copy of the cache array, totals and geometry, predicts each
// access outcome and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module salc_checker
    import salc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    salc_req_if  req,
    salc_rsp_if  rsp,
    salc_cfg_if  cfg,
    output int   fail_count,
    output int   open_results,
    output int   items_taken,
    output int   results_taken,
    output int   hits_taken,
    output int   evicts_taken
);

    localparam int LINES = SETS * WAYS;

    typedef struct {
        outcome_e         outcome;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
        logic             last_of_item;
    } access_result_t;

    // shadow cache array and totals
    logic             line_valid [LINES];
    logic [63:0]      line_tag   [LINES];
    logic [AGE_W-1:0] line_age   [LINES];
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] miss_cnt;
    logic [CNT_W-1:0] evict_cnt;

    logic [CFG_SET_W-1:0]    set_bits_cfg;
    logic [CFG_WAYS_W-1:0]   ways_cfg;
    logic [CFG_OFFSET_W-1:0] offset_cfg;

    access_result_t expected_results [$];
    access_result_t want;
    access_result_t got;
    int fails;
    int n_items;
    int n_results;
    int n_hits;
    int n_evicts;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // one lookup with fill or LRU replacement, updates the shadow state
    function automatic outcome_e cache_lookup(logic [31:0] addr);
        int          sbits;
        int          nways;
        int          shift;
        int          set_idx;
        int          base;
        int          victim;
        logic [63:0] a;
        logic [63:0] tag;
        a     = {32'd0, addr};
        sbits = (set_bits_cfg > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_cfg);
        nways = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : int'(ways_cfg));
        shift = int'(offset_cfg) + sbits;
        set_idx = int'((a >> offset_cfg) & ((64'd1 << sbits) - 64'd1));
        tag   = (shift >= 64) ? 64'd0 : (a >> shift);
        base  = set_idx * WAYS;
        for (int w = 0; w < nways; w++) begin
            if (line_valid[base + w] && line_tag[base + w] == tag) begin
                line_age[base + w] = '0;
                hit_cnt = sat_inc(hit_cnt);
                return OUT_HIT;
            end
        end
        for (int w = 0; w < nways; w++) begin
            if (!line_valid[base + w]) begin
                line_valid[base + w] = 1'b1;
                line_tag[base + w]   = tag;
                line_age[base + w]   = '0;
                miss_cnt = sat_inc(miss_cnt);
                return OUT_FILL;
            end
        end
        victim = 0;
        for (int w = 1; w < nways; w++) begin
            if (line_age[base + w] > line_age[base + victim])
                victim = w;
        end
        line_tag[base + victim] = tag;
        line_age[base + victim] = '0;
        miss_cnt  = sat_inc(miss_cnt);
        evict_cnt = sat_inc(evict_cnt);
        return OUT_EVICT;
    endfunction

    function automatic void queue_result(outcome_e oc, logic last);
        access_result_t r;
        r.outcome        = oc;
        r.hit_total      = hit_cnt;
        r.miss_total     = miss_cnt;
        r.eviction_total = evict_cnt;
        r.last_of_item   = last;
        expected_results.push_back(r);
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_age[i]   = '0;
            end
            hit_cnt      = '0;
            miss_cnt     = '0;
            evict_cnt    = '0;
            set_bits_cfg = SET_BITS_RST;
            ways_cfg     = WAYS_RST;
            offset_cfg   = OFFSET_RST;
            expected_results.delete();
            fails     = 0;
            n_items   = 0;
            n_results = 0;
            n_hits    = 0;
            n_evicts  = 0;
        end else begin
            // result side first: it always belongs to an older item
            if (rsp.valid && rsp.ready) begin
                got.outcome        = outcome_e'(rsp.outcome);
                got.hit_total      = rsp.hit_total;
                got.miss_total     = rsp.miss_total;
                got.eviction_total = rsp.eviction_total;
                got.last_of_item   = rsp.last_of_item;
                n_results++;
                if (got.outcome == OUT_HIT)
                    n_hits++;
                if (got.outcome == OUT_EVICT)
                    n_evicts++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no access pending (outcome %0d)",
                           rsp.outcome);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    fails += field_mismatch("outcome", 32'(want.outcome), 32'(rsp.outcome));
                    fails += field_mismatch("hit_total", want.hit_total, got.hit_total);
                    fails += field_mismatch("miss_total", want.miss_total, got.miss_total);
                    fails += field_mismatch("eviction_total", want.eviction_total,
                                            got.eviction_total);
                    fails += field_mismatch("last_of_item", 32'(want.last_of_item),
                                            32'(got.last_of_item));
                end
            end

            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_SET_BITS:    set_bits_cfg = cfg.data[CFG_SET_W-1:0];
                    REG_WAYS:        ways_cfg     = cfg.data[CFG_WAYS_W-1:0];
                    REG_OFFSET_BITS: offset_cfg   = cfg.data[CFG_OFFSET_W-1:0];
                    default:         ;
                endcase
            end

            if (req.valid && req.ready) begin
                n_items++;
                case (req.command)
                    CMD_MODIFY: begin
                        queue_result(cache_lookup(req.address), 1'b0);
                        queue_result(cache_lookup(req.address), 1'b1);
                    end
                    CMD_LOAD, CMD_STORE: queue_result(cache_lookup(req.address), 1'b1);
                    default: ;
                endcase
                // every valid line ages once per item, whatever the geometry
                for (int i = 0; i < LINES; i++) begin
                    if (line_valid[i])
                        line_age[i] = sat_inc(line_age[i]);
                end
            end
        end

        fail_count    <= fails;
        open_results  <= expected_results.size();
        items_taken   <= n_items;
        results_taken <= n_results;
        hits_taken    <= n_hits;
        evicts_taken  <= n_evicts;
    end

endmodule

// ===== bench/tb_set_assoc_lru_cache_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model
// Drives loads, stores, modifies and command 3 into the LRU cache model over a range of
// cache geometries, with random stalls on both sides, and reports the verdict
// from the checker's failure count and its count of open results.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_model;
    import salc_pkg::*;

    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int SETTLE       = 20;
    localparam int SEGMENTS     = 11;
    localparam int SEG_ACCESSES = 46;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    salc_req_if req_ch ();
    salc_rsp_if rsp_ch ();
    salc_cfg_if cfg_ch ();

    int fail_count;
    int open_results;
    int items_taken;
    int results_taken;
    int hits_taken;
    int evicts_taken;

    int send_idle_pct = 21;
    int rcv_idle_pct = 59;
    int hold_len = 0;
    int hold_seq = 0;

    // geometry in effect, used to aim addresses at a few sets
    int cur_sbits;
    int cur_ways;
    int cur_off;
    int settings_used = 0;
    logic [31:0] addr_pool [$];

    // per segment: set bits, ways, offset bits as written to the registers
    int seg_sbits [SEGMENTS] = '{4, 2, 0, 6, 7, 3, 1, 5, 6, 2, 4};
    int seg_ways  [SEGMENTS] = '{1, 4, 8, 8, 15, 0, 2, 3, 8, 6, 8};
    int seg_off   [SEGMENTS] = '{4, 2, 0, 26, 31, 5, 3, 7, 12, 30, 4};

    set_assoc_lru_cache_model u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    salc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .open_results  (open_results),
        .items_taken   (items_taken),
        .results_taken (results_taken),
        .hits_taken    (hits_taken),
        .evicts_taken  (evicts_taken)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls plus a long hold-off
    initial
    begin
        int seen_seq;
        int hold_left;
        seen_seq  = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq  = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic offer_access(logic [1:0] cmd, logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // stop offering, let every result come back, then give a no-result item time to finish
    task automatic quiesce();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (open_results != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic set_geometry(int sbits, int ways, int off, bit poke_spare);
        logic [4:0]  d;
        logic [63:0] a;
        logic [63:0] set_mask;
        int          nsets;
        int          ntags;
        logic [31:0] tag_base;
        logic [31:0] set_base;
        quiesce();
        // unused upper data bits are randomized, the block must ignore them
        d = 5'($urandom);
        d[2:0] = 3'(sbits);
        write_reg(REG_SET_BITS, d);
        d = 5'($urandom);
        d[3:0] = 4'(ways);
        write_reg(REG_WAYS, d);
        write_reg(REG_OFFSET_BITS, 5'(off));
        if (poke_spare)
            write_reg(REG_SPARE, 5'($urandom));
        cfg_ch.valid <= 1'b0;
        settings_used++;

        cur_sbits = (sbits > SET_BITS_MAX) ? SET_BITS_MAX : sbits;
        cur_ways  = (ways == 0) ? 1 : ((ways > WAYS) ? WAYS : ways);
        cur_off   = off;
        // a few sets with more tags than ways, so lines get evicted
        addr_pool.delete();
        nsets    = $urandom_range(1, 3);
        ntags    = cur_ways + $urandom_range(1, 3);
        tag_base = $urandom;
        set_base = $urandom;
        set_mask = (64'd1 << cur_sbits) - 64'd1;
        for (int s = 0; s < nsets; s++)
        begin
            for (int t = 0; t < ntags; t++)
            begin
                a = (64'(tag_base + t) << (cur_off + cur_sbits)) |
                    ((64'(set_base + s) & set_mask) << cur_off);
                addr_pool.push_back(a[31:0]);
            end
        end
    endtask

    // returns 1 when the access produces results
    task automatic random_access(output bit counted);
        int          r;
        logic [63:0] off_mask;
        logic [31:0] addr;
        r = $urandom_range(99);
        off_mask = (64'd1 << cur_off) - 64'd1;
        if (r < 5)
        begin
            offer_access(CMD_NONE, $urandom);
            counted = 1'b0;
        end
        else
        begin
            if (r < 80)
                addr = addr_pool[$urandom_range(addr_pool.size() - 1)] |
                       ($urandom & off_mask[31:0]);
            else
                addr = $urandom;
            offer_access(2'($urandom_range(2)), addr);
            counted = 1'b1;
        end
    endtask

    initial
    begin
        int n;
        bit counted;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_LOAD;
        req_ch.address <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_SET_BITS;
        cfg_ch.data    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 16 sets, one way, 16-byte blocks
        cur_sbits = 4;
        cur_ways  = 1;
        cur_off   = 4;
        offer_access(CMD_LOAD,   32'h0000_0000);
        offer_access(CMD_LOAD,   32'h0000_000F);
        offer_access(CMD_STORE,  32'hFFFF_FFFF);
        offer_access(CMD_MODIFY, 32'h0000_0100);
        offer_access(CMD_NONE,   32'h1234_5678);
        offer_access(CMD_LOAD,   32'h0000_0000);

        // no set bits: everything lands in set 0
        set_geometry(0, 2, 0, 1'b1);
        offer_access(CMD_LOAD,   32'hAAAA_AAAA);
        offer_access(CMD_LOAD,   32'h5555_5555);
        offer_access(CMD_LOAD,   32'hAAAA_AAAA);
        offer_access(CMD_STORE,  32'h0000_0001);
        offer_access(CMD_MODIFY, 32'h8000_0000);

        // set bits and way count out of range, tag shift beyond the address
        set_geometry(7, 0, 31, 1'b0);
        offer_access(CMD_LOAD,   32'hFFFF_FFFF);
        offer_access(CMD_LOAD,   32'h8000_0000);
        offer_access(CMD_STORE,  32'h7FFF_FFFF);
        offer_access(CMD_MODIFY, 32'h0000_0000);

        // widen back out: lines written under the old geometry must still hit
        set_geometry(0, 15, 0, 1'b0);
        offer_access(CMD_LOAD,   32'h8000_0000);
        offer_access(CMD_LOAD,   32'h0000_0001);
        offer_access(CMD_STORE,  32'h0000_0010);
        offer_access(CMD_STORE,  32'h0000_0020);
        offer_access(CMD_MODIFY, 32'h0000_0030);
        offer_access(CMD_LOAD,   32'hAAAA_AAAA);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 4)
            begin
                send_idle_pct = 21;
                rcv_idle_pct  = 59;
            end
            else if (seg < 8)
            begin
                send_idle_pct = 59;
                rcv_idle_pct  = 21;
            end
            else
            begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            set_geometry(seg_sbits[seg], seg_ways[seg], seg_off[seg], 1'b0);
            n = 0;
            while (n < SEG_ACCESSES)
            begin
                // long result stall while requests keep coming
                if (seg == 0 && n == 10)
                begin
                    hold_len <= 200;
                    hold_seq <= hold_seq + 1;
                end
                if (seg == 5 && n == 25)
                    quiesce();
                random_access(counted);
                if (counted)
                    n++;
            end
        end

        quiesce();
        $display("covered %0d accesses over %0d register settings", items_taken,
                 settings_used);
        $display("%0d results checked: %0d hits, %0d evictions", results_taken, hits_taken,
                 evicts_taken);
        if (fail_count == 0 && open_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/salc_pkg.sv
hdl/salc_req_if.sv
hdl/salc_rsp_if.sv
hdl/salc_cfg_if.sv
hdl/salc_ram.sv
hdl/salc_way_eval.sv
hdl/set_assoc_lru_cache_model.sv
bench/salc_checker.sv
bench/tb_set_assoc_lru_cache_model.sv
